/* sv/dbs_pkg.sv */
// ----------------------------------------------------------------------------
// dbs_pkg: shared types and constants
// Payload structs, sequencer codes and sizes for the deadline batch scheduler.
// ----------------------------------------------------------------------------
package dbs_pkg;

  localparam int CAPACITY = 256;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int OCC_W    = ADDR_W + 1;
  localparam int MAX_BATCH = 16;
  localparam int BS_W     = 5;
  localparam int CNT_W    = 24;
  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
  localparam logic [15:0] TIME_MAX = 16'hFFFF;

  localparam logic REQ_ARRIVE = 1'b0;
  localparam logic REQ_TICK   = 1'b1;

  localparam logic [1:0] KIND_MEMBER   = 2'd0;
  localparam logic [1:0] KIND_NO_BATCH = 2'd1;
  localparam logic [1:0] KIND_REJECT   = 2'd2;

  typedef struct packed {
    logic        req_type;
    logic [15:0] job_id;
    logic [15:0] deadline;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [15:0]      served_id;
    logic [CNT_W-1:0] batch_total;
    logic             last;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_REJ, S_EXP_RD, S_EXP_CHK, S_EXP_WR, S_DECIDE,
    S_NOBATCH, S_MIN_RD, S_MIN_CMP, S_REM_WR, S_FIN
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_ACCEPT, OP_ARRIVE, OP_REJ, OP_EXP_INIT, OP_EXP_RD,
    OP_EXP_MVRD, OP_EXP_WR, OP_EXP_INC, OP_BATCH_INIT, OP_NOBATCH,
    OP_MIN_RD, OP_MIN_CMP, OP_REM_RD, OP_REM_WR, OP_TIME_INC
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dbs_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic full;
    logic i_lt_occ;
    logic expired;
    logic occ_ge_b;
    logic j_lt_occ;
    logic k_last;
    logic out_free;
  } dbs_status_t;

endpackage

/* sv/dbs_ctrl.sv */
// ----------------------------------------------------------------------------
// dbs_ctrl: sequencer
// Steps the datapath through arrival, expiry scan, minimum search and removal.
// ----------------------------------------------------------------------------
module dbs_ctrl
  import dbs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  dbs_status_t status,
  output dbs_cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    in_stall   = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.op     = OP_ACCEPT;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (status.is_tick) begin
          cmd.op     = OP_EXP_INIT;
          state_next = S_EXP_RD;
        end else if (status.full) begin
          state_next = S_REJ;
        end else begin
          cmd.op     = OP_ARRIVE;
          state_next = S_IDLE;
        end
      end
      S_REJ: begin
        if (status.out_free) begin
          cmd.op     = OP_REJ;
          state_next = S_IDLE;
        end
      end
      S_EXP_RD: begin
        if (status.i_lt_occ) begin
          cmd.op     = OP_EXP_RD;
          state_next = S_EXP_CHK;
        end else begin
          state_next = S_DECIDE;
        end
      end
      S_EXP_CHK: begin
        // An expired entry is replaced by the last one, which is then rechecked.
        if (status.expired) begin
          cmd.op     = OP_EXP_MVRD;
          state_next = S_EXP_WR;
        end else begin
          cmd.op     = OP_EXP_INC;
          state_next = S_EXP_RD;
        end
      end
      S_EXP_WR: begin
        cmd.op     = OP_EXP_WR;
        state_next = S_EXP_RD;
      end
      S_DECIDE: begin
        if (status.occ_ge_b) begin
          cmd.op     = OP_BATCH_INIT;
          state_next = S_MIN_RD;
        end else begin
          state_next = S_NOBATCH;
        end
      end
      S_NOBATCH: begin
        if (status.out_free) begin
          cmd.op     = OP_NOBATCH;
          state_next = S_FIN;
        end
      end
      S_MIN_RD: begin
        if (status.j_lt_occ) begin
          cmd.op     = OP_MIN_RD;
          state_next = S_MIN_CMP;
        end else begin
          cmd.op     = OP_REM_RD;
          state_next = S_REM_WR;
        end
      end
      S_MIN_CMP: begin
        cmd.op     = OP_MIN_CMP;
        state_next = S_MIN_RD;
      end
      S_REM_WR: begin
        if (status.out_free) begin
          cmd.op     = OP_REM_WR;
          state_next = status.k_last ? S_FIN : S_MIN_RD;
        end
      end
      S_FIN: begin
        cmd.op     = OP_TIME_INC;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* sv/dbs_dp.sv */
// ----------------------------------------------------------------------------
// dbs_dp: datapath
// Pending store, occupancy, time, batch counter, scan indexes and result register.
// ----------------------------------------------------------------------------
module dbs_dp
  import dbs_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [BS_W-1:0] cfg_data,
  input  in_item_t        in_item,
  input  dbs_cmd_t        cmd,
  output dbs_status_t     status,
  output logic            out_valid,
  input  logic            out_stall,
  output out_item_t       out_item
);

  logic [31:0]       mem [CAPACITY];
  logic [31:0]       rd_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [31:0]       wr_data;

  in_item_t          item;
  logic [OCC_W-1:0]  occ;
  logic [15:0]       cur_time;
  logic [CNT_W-1:0]  batch_count;
  logic [BS_W-1:0]   batch_size;
  logic [BS_W-1:0]   beff;
  logic [BS_W-1:0]   k;
  logic [OCC_W-1:0]  i;
  logic [OCC_W-1:0]  j;
  logic [ADDR_W-1:0] best;
  logic [31:0]       best_key;
  logic [OCC_W-1:0]  occ_m1;
  logic              load_out;
  out_item_t         out_next;

  assign occ_m1 = occ - OCC_W'(1);

  // Read data is held between reads, so a removal that waits on the output
  // register still writes back the entry it fetched.
  always_comb begin
    rd_en = 1'b1;
    case (cmd.op)
      OP_EXP_RD:                rd_addr = i[ADDR_W-1:0];
      OP_EXP_MVRD, OP_REM_RD:   rd_addr = occ_m1[ADDR_W-1:0];
      OP_MIN_RD:                rd_addr = j[ADDR_W-1:0];
      default: begin
        rd_en   = 1'b0;
        rd_addr = '0;
      end
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = rd_data;
    case (cmd.op)
      OP_ARRIVE: begin
        wr_en   = 1'b1;
        wr_addr = occ[ADDR_W-1:0];
        wr_data = {item.deadline, item.job_id};
      end
      OP_EXP_WR: begin
        wr_en   = 1'b1;
        wr_addr = i[ADDR_W-1:0];
      end
      OP_REM_WR: begin
        wr_en   = 1'b1;
        wr_addr = best;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_comb begin
    load_out = 1'b0;
    out_next = out_item;
    case (cmd.op)
      OP_REJ: begin
        load_out = 1'b1;
        out_next = '{kind: KIND_REJECT, served_id: item.job_id,
                     batch_total: batch_count, last: 1'b1};
      end
      OP_NOBATCH: begin
        load_out = 1'b1;
        out_next = '{kind: KIND_NO_BATCH, served_id: 16'd0,
                     batch_total: batch_count, last: 1'b1};
      end
      OP_REM_WR: begin
        load_out = 1'b1;
        out_next = '{kind: KIND_MEMBER, served_id: best_key[15:0],
                     batch_total: batch_count, last: status.k_last};
      end
      default: begin
        load_out = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (load_out) begin
      out_item <= out_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ         <= '0;
      cur_time    <= 16'd1;
      batch_count <= '0;
      batch_size  <= BS_W'(1);
    end else begin
      if (cfg_we) begin
        batch_size <= cfg_data;
      end
      case (cmd.op)
        OP_ARRIVE: occ <= occ + OCC_W'(1);
        OP_EXP_MVRD, OP_REM_RD: occ <= occ_m1;
        OP_BATCH_INIT: begin
          if (batch_count != COUNT_MAX) begin
            batch_count <= batch_count + CNT_W'(1);
          end
        end
        OP_TIME_INC: begin
          if (cur_time != TIME_MAX) begin
            cur_time <= cur_time + 16'd1;
          end
        end
        default: begin
          occ <= occ;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_ACCEPT: item <= in_item;
      OP_EXP_INIT: begin
        i <= '0;
        if (batch_size == '0) begin
          beff <= BS_W'(1);
        end else if (batch_size > BS_W'(MAX_BATCH)) begin
          beff <= BS_W'(MAX_BATCH);
        end else begin
          beff <= batch_size;
        end
      end
      OP_EXP_INC: i <= i + OCC_W'(1);
      OP_BATCH_INIT: begin
        k <= '0;
        j <= '0;
      end
      OP_MIN_CMP: begin
        if (j == '0 || rd_data < best_key) begin
          best     <= j[ADDR_W-1:0];
          best_key <= rd_data;
        end
        j <= j + OCC_W'(1);
      end
      OP_REM_WR: begin
        k <= k + BS_W'(1);
        j <= '0;
      end
      default: begin
        i <= i;
      end
    endcase
  end

  always_comb begin
    status.is_tick  = (item.req_type == REQ_TICK);
    status.full     = occ[OCC_W-1];
    status.i_lt_occ = (i < occ);
    status.expired  = (rd_data[31:16] < cur_time);
    status.occ_ge_b = (occ >= OCC_W'(beff));
    status.j_lt_occ = (j < occ);
    status.k_last   = (k + BS_W'(1) == beff);
    status.out_free = !out_valid || !out_stall;
  end

endmodule

/* sv/deadline_batch_scheduler_top.sv */
// ----------------------------------------------------------------------------
// deadline_batch_scheduler_top: earliest-deadline-first batch scheduler
// Stores pending jobs and serves the earliest ones as a batch on each tick that finds enough pending.
// ----------------------------------------------------------------------------
// No new item is taken until an arrival is stored or rejected or a tick is done.
// A tick runs the expiry scan, then beff minimum searches that each serve and remove
// the earliest entry, or gives a no-batch result when fewer than beff are pending;
// beff is the clamped batch size. The pending store has one read and one write port.
// Results leave through one output register; a stalled output holds the sequencer.
// Synchronous reset empties the store, sets time to 1 and batch size to 1.

module deadline_batch_scheduler_top
  import dbs_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [BS_W-1:0] cfg_data,
  input  logic            in_valid,
  output logic            in_stall,
  input  in_item_t        in_item,
  output logic            out_valid,
  input  logic            out_stall,
  output out_item_t       out_item
);

  dbs_cmd_t    cmd;
  dbs_status_t status;

  dbs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  dbs_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // A result is only loaded when the output register can take it.
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_REJ || cmd.op == OP_NOBATCH || cmd.op == OP_REM_WR)
      |-> status.out_free)
    else $error("result loaded over a pending result");

  // After an item is taken the block is busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("item accepted back to back");

  // An arrival is never written into a full store.
  a_no_write_full: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_ARRIVE) |-> !status.full)
    else $error("arrival written into full store");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result dropped");

endmodule
